[rtl/pfs_pkg.sv]
package pfs_pkg;

    // width of the value and factor fields on the channels
    localparam int FIELD_WIDTH = 32;

    // default working width of the factoriser
    localparam int VALUE_WIDTH_DEF = 32;

    // divider handshake towards the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

[rtl/pfs_if.sv]
// input channel: one value per transaction
interface pfs_in_if import pfs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// output channel: one factor per transaction
interface pfs_out_if import pfs_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [FIELD_WIDTH-1:0] factor;
    logic                   last;
    logic                   empty_res;

    modport source (output valid, output factor, output last, output empty_res,
                    input ready);
    modport sink   (input valid, input factor, input last, input empty_res,
                    output ready);
endinterface

[rtl/prime_factor_stream_core.sv]
// channel   | dir | payload                     | transaction
// i_in      | in  | value[31:0]                 | valid & ready
// o_out     | out | factor[31:0], last, empty_res | valid & ready
//
// each trial divisor costs one pass of the bit-serial divider
// (DW = min(VALUE_WIDTH, 32)); a value takes about sqrt(n) + factors passes.
// i_rst_n is synchronous and clears the sequencer, divider and output valid.
// a stalled output holds the sequencer at the next result; the next value is
// taken while the final result of the previous one still waits in the output register.
module prime_factor_stream_core import pfs_pkg::*; #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pfs_in_if.sink    i_in,
    pfs_out_if.source o_out
);

    localparam int DW = (VALUE_WIDTH < FIELD_WIDTH) ? VALUE_WIDTH : FIELD_WIDTH;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]    r_state;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_d;
    logic [DW-1:0] r_emit_val;
    logic          r_emit_last;
    logic          r_emit_empty;

    logic                   r_out_valid;
    logic [FIELD_WIDTH-1:0] r_out_factor;
    logic                   r_out_last;
    logic                   r_out_empty;

    t_div_status   div_status;
    logic [DW-1:0] div_quo;
    logic [DW-1:0] div_rem;
    logic          div_start;
    logic [DW-1:0] in_val;
    logic          in_take;
    logic          out_free;

    assign in_val    = i_in.value[DW-1:0];
    assign in_take   = i_in.valid && i_in.ready;
    assign out_free  = !r_out_valid || o_out.ready;
    assign div_start = (r_state == S_DIV);

    pfs_div #(.DW(DW)) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_rem),
        .i_divisor   (r_d),
        .o_status    (div_status),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    // sequencer: trial division with quotient-below-divisor as the stop test
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        if (in_val < DW'(2)) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_status.done) begin
                        if (div_quo < r_d || div_rem == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= r_emit_last ? S_IDLE : S_DIV;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // remainder, divisor and pending result
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_rem        <= in_val;
                r_d          <= DW'(2);
                r_emit_val   <= '0;
                r_emit_last  <= 1'b1;
                r_emit_empty <= 1'b1;
            end
            S_WAIT: begin
                if (div_status.done) begin
                    r_emit_empty <= 1'b0;
                    if (div_quo < r_d) begin
                        r_emit_val  <= r_rem;
                        r_emit_last <= 1'b1;
                    end else if (div_rem == '0) begin
                        r_emit_val  <= r_d;
                        r_emit_last <= 1'b0;
                        r_rem       <= div_quo;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_factor <= FIELD_WIDTH'(r_emit_val);
            r_out_last   <= r_emit_last;
            r_out_empty  <= r_emit_empty;
        end
    end

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.factor    = r_out_factor;
    assign o_out.last      = r_out_last;
    assign o_out.empty_res = r_out_empty;

endmodule

[rtl/pfs_div.sv]
module pfs_div import pfs_pkg::*; #(
    parameter int DW = VALUE_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_status   o_status,
    output logic [DW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_acc, n_acc;
    logic [DW-1:0] r_quo, n_quo;
    logic [DW-1:0] r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    // one restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        shifted = {r_acc, r_quo[DW-1]};
        diff    = shifted - {1'b0, r_dvs};
        if (!diff[DW]) begin
            n_acc = diff[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b1};
        end else begin
            n_acc = shifted[DW-1:0];
            n_quo = {r_quo[DW-2:0], 1'b0};
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_quo <= n_quo;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quotient    = r_quo;
    assign o_remainder   = r_acc;

endmodule

[test/prime_factor_stream_core_test.sv]
`timescale 1ns / 1ps

module prime_factor_stream_core_test;
    import pfs_pkg::*;

    // one predicted factor transaction
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] factor;
        logic                   last;
        logic                   empty_res;
    } t_factor_result;

    // largest trial divisor allowed for random values, keeps each one cheap
    localparam int unsigned REACH_LIMIT = 1024;
    localparam int unsigned IDLE_PCT    = 13;

    logic i_clk;
    logic i_rst_n;

    pfs_in_if  in_ch ();
    pfs_out_if out_ch ();

    prime_factor_stream_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    logic [FIELD_WIDTH-1:0] value_queue[$];
    t_factor_result         factor_run[$];
    t_factor_result         factors_due[$];
    int unsigned            values_sent;
    int unsigned            mismatches;
    logic                   calm;

    // append one value to the pending queue
    function automatic void queue_value(input logic [FIELD_WIDTH-1:0] v);
        value_queue = {value_queue, v};
    endfunction

    // trial division of one value into factor_run, reach is d when the loop ends
    function automatic void factorise(input logic [FIELD_WIDTH-1:0] value,
                                      output int unsigned reach);
        logic [63:0]    rem;
        logic [63:0]    d;
        t_factor_result r;
        factor_run.delete();
        rem   = 64'(value);
        d     = 64'd2;
        reach = 0;
        if (rem < 64'd2) begin
            r.factor    = '0;
            r.last      = 1'b1;
            r.empty_res = 1'b1;
            factor_run  = {factor_run, r};
            return;
        end
        while (d * d <= rem) begin
            if (rem % d == 64'd0) begin
                r.factor    = d[FIELD_WIDTH-1:0];
                r.last      = 1'b0;
                r.empty_res = 1'b0;
                factor_run  = {factor_run, r};
                rem = rem / d;
            end else begin
                d = d + 64'd1;
            end
        end
        if (rem > 64'd1) begin
            r.factor    = rem[FIELD_WIDTH-1:0];
            r.last      = 1'b0;
            r.empty_res = 1'b0;
            factor_run  = {factor_run, r};
        end
        factor_run[factor_run.size() - 1].last = 1'b1;
        reach = d[31:0];
    endfunction

    // random value: a product of factors below 65536 or a raw value of random length
    function automatic logic [FIELD_WIDTH-1:0] random_value();
        logic [63:0]  prod;
        logic [63:0]  f;
        int unsigned  bound;
        int unsigned  count;
        if ($urandom_range(0, 1) == 0) begin
            prod  = 64'd1;
            count = $urandom_range(1, 31);
            case ($urandom_range(0, 2))
                0: bound = 3;
                1: bound = 16;
                default: bound = 300;
            endcase
            for (int i = 0; i < count; i++) begin
                f = 64'($urandom_range(2, bound));
                if (prod * f <= 64'hFFFF_FFFF) prod = prod * f;
            end
            f = 64'($urandom_range(1, 65535));
            if ($urandom_range(0, 1) == 1 && prod * f <= 64'hFFFF_FFFF) prod = prod * f;
            return prod[FIELD_WIDTH-1:0];
        end
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // known levels before the first edge
    initial begin
        in_ch.valid  = 1'b0;
        in_ch.value  = '0;
        out_ch.ready = 1'b0;
    end

    // long stretch with no idling on either side
    assign calm = (values_sent >= 60) && (values_sent < 85);

    // driver: presents queued values, predicts factors on each transaction
    always @(posedge i_clk) begin
        int unsigned reach;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.value <= '0;
            values_sent <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                factorise(in_ch.value, reach);
                factors_due = {factors_due, factor_run};
                values_sent <= values_sent + 1;
            end
            if (value_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_ch.valid <= 1'b1;
                in_ch.value <= value_queue.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
                in_ch.value <= $urandom;
            end
        end
    end

    // monitor: checks each factor transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_factor_result want;
        int unsigned    errs;
        errs = 0;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            mismatches   <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (factors_due.size() == 0) begin
                    $error("unexpected transaction: factor %0d last %0b empty_res %0b",
                           out_ch.factor, out_ch.last, out_ch.empty_res);
                    errs = errs + 1;
                end else begin
                    want = factors_due.pop_front();
                    if (out_ch.factor !== want.factor) begin
                        $error("factor: expected %0d, actual %0d", want.factor, out_ch.factor);
                        errs = errs + 1;
                    end
                    if (out_ch.last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, out_ch.last);
                        errs = errs + 1;
                    end
                    if (out_ch.empty_res !== want.empty_res) begin
                        $error("empty_res: expected %0b, actual %0b",
                               want.empty_res, out_ch.empty_res);
                        errs = errs + 1;
                    end
                end
            end
            mismatches   <= mismatches + errs;
            out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // stimulus and end of run
    initial begin
        logic [FIELD_WIDTH-1:0] v;
        int unsigned            reach;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty inputs, smallest primes, field extremes, long runs, largest cheap primes
        queue_value(32'd0);
        queue_value(32'd1);
        queue_value(32'd2);
        queue_value(32'd3);
        queue_value(32'd4);
        queue_value(32'd6);
        queue_value(32'd97);
        queue_value(32'hFFFF_FFFF);
        queue_value(32'h8000_0000);
        queue_value(32'hAAAA_AAAA);
        queue_value(32'h5555_5555);
        queue_value(32'd65521);
        queue_value(32'd65536);
        queue_value(32'd65537);
        queue_value(32'd1048573);
        queue_value(32'd4293853184);
        queue_value(32'd3969126001);
        queue_value(32'd3486784401);
        queue_value(32'd223092870);
        queue_value(32'd1);
        queue_value(32'd0);

        for (int batch = 0; batch < 3; batch++) begin
            // sender holds off until every predicted factor has arrived
            while (value_queue.size() != 0 || in_ch.valid || factors_due.size() != 0)
                @(negedge i_clk);
            if (batch < 2) begin
                for (int n = 0; n < 50; n++) begin
                    do begin
                        v = random_value();
                        factorise(v, reach);
                    end while (reach > REACH_LIMIT);
                    queue_value(v);
                end
            end
        end

        repeat (100) @(posedge i_clk);
        if (mismatches == 0 && factors_due.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
